/* design/psb_pkg.sv */
// Shared constants, types and state codes of the (k, mu) power spectrum binner.
package psb_pkg;

  localparam int GRID_SIZE = 256;
  localparam int MAX_BINS  = 64;
  localparam int HALF      = GRID_SIZE / 2;
  localparam int LOW_WAVE  = HALF + 1 - GRID_SIZE;
  localparam int ADDR_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic PART_REAL = 1'b0;

  typedef enum logic [2:0] {
    CFG_K_START,
    CFG_K_WIDTH,
    CFG_K_BINS,
    CFG_MU_BINS,
    CFG_SIGHT_AXIS,
    CFG_PART_SELECT,
    CFG_SHOT_NOISE,
    CFG_POWER_SCALE
  } cfg_idx_e;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_SQK,
    S_KCHK,
    S_KDIV,
    S_KQ,
    S_MT,
    S_MTT,
    S_QDIV,
    S_QQ,
    S_QSQ,
    S_MUB,
    S_MUDIV,
    S_XP1,
    S_XP2,
    S_XF,
    S_XW1,
    S_XW2,
    S_XW3,
    S_UPD,
    S_FRD,
    S_FWT,
    S_FDK,
    S_FMK,
    S_FDM,
    S_FMM,
    S_FDP,
    S_FS1,
    S_FS2,
    S_FS3,
    S_FNX
  } state_e;

  typedef struct packed {
    logic        [23:0] count;
    logic        [39:0] k_sum;
    logic        [39:0] mu_sum;
    logic signed [63:0] power_sum;
  } bin_entry_t;

  localparam int ENTRY_W = $bits(bin_entry_t);

endpackage

/* design/psb_ram.sv */
// Generic single-port-write, registered-read RAM.
module psb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/power_spectrum_2d_binner.sv */
// Top level of the (k, mu) binned power spectrum accumulator.
//
// A request is taken when start is high and busy is low. An accumulate request
// (cmd 0) bins one Fourier mode and returns nothing; it keeps busy high until
// the mode is stored or dropped. It uses one shared restoring shift/subtract
// unit, which runs the 24-step square root for |k|, the 24-step k-bin
// division, the 28-step and 14-step division and root for the mu bin and the
// 18-step division for mu, plus a shared 33x33 multiplier for the cross
// power. A finish request (cmd 1) emits min(k_bins * mu_bins, 64) bins in
// order, one result per strobe on valid_o, with last_o on the final one; an
// empty bin skips the divisions, a filled bin runs three divisions by the
// count (of 40, 40 and 64 steps).
// The receiver cannot stall: each result is shown for exactly one cycle. The
// bin store is a 64-entry RAM with one valid flop per entry, so reset and the
// clear after finish take effect at once. Write configuration only while busy
// is low. Modes with a negative line-of-sight component are dropped.
module power_spectrum_2d_binner (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic        [7:0]  wave_x_i,
  input  logic        [7:0]  wave_y_i,
  input  logic        [7:0]  wave_z_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  input  logic        [19:0] weight_i,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [47:0] cfg_data_i,
  // result channel
  output logic               valid_o,
  output logic        [5:0]  bin_index_o,
  output logic        [23:0] mode_count_o,
  output logic        [23:0] mean_k_o,
  output logic signed [17:0] mean_mu_o,
  output logic signed [47:0] power_o,
  output logic               last_o
);

  localparam int AW = psb_pkg::ADDR_W;

  psb_pkg::state_e state_q, state_d;

  // configuration registers
  logic        [15:0] k_start_q, k_width_q;
  logic        [6:0]  k_bins_q, mu_bins_q;
  logic        [1:0]  sight_q;
  logic               part_q;
  logic signed [47:0] shot_q;
  logic        [31:0] scale_q;

  // latched request
  logic               cmd_q;
  logic        [7:0]  kx_q, ky_q, kz_q;
  logic signed [31:0] are_q, aim_q, bre_q, bim_q;
  logic        [19:0] w_q;

  // per-mode working registers
  logic        [15:0] k2_q;
  logic        [6:0]  klos_q;
  logic        [23:0] kmag_q;
  logic        [6:0]  ik_q;
  logic        [AW-1:0] bin_q;
  logic        [16:0] mu_q;
  logic signed [48:0] t1_q;
  logic        [47:0] fm_q;
  logic               fneg_q;
  logic        [63:0] hi_q;
  logic signed [63:0] term_q;

  // shared shift/subtract unit
  logic        [25:0] rem_q;
  logic        [63:0] dq_q;
  logic        [23:0] root_q;
  logic        [23:0] dvs_q;
  logic        [6:0]  cnt_q;

  // finish sequencing
  logic        [AW-1:0] idx_q;
  logic        [6:0]  n_q;
  logic        [63:0] psum_q;

  // result registers
  logic               out_valid_q;
  logic        [5:0]  bin_index_q;
  logic        [23:0] mode_count_q, mean_k_q;
  logic signed [17:0] mean_mu_q;
  logic signed [47:0] power_q;
  logic               last_q;

  logic [psb_pkg::MAX_BINS-1:0] bv_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // store access
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_raddr;
  psb_pkg::bin_entry_t   ram_wdata, ent;
  logic [psb_pkg::ENTRY_W-1:0] ram_rdata;
  logic [AW-1:0]         ent_addr;

  logic accept;
  assign accept = start && (state_q == psb_pkg::S_IDLE);
  assign busy   = (state_q != psb_pkg::S_IDLE);

  // ---------------------------------------------------------------------------
  // Shared unit step: one sqrt digit or one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [27:0] sq_rem2, sq_trial;
  logic        sq_ge;
  logic [25:0] sq_rem_nx;
  logic [23:0] sq_root_nx;
  logic [26:0] dv_rem2;
  logic        dv_ge;
  logic [25:0] dv_rem_nx;

  always_comb begin
    sq_rem2    = {rem_q, dq_q[63:62]};
    sq_trial   = {2'b00, root_q, 2'b01};
    sq_ge      = (sq_rem2 >= sq_trial);
    sq_rem_nx  = sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];
    sq_root_nx = {root_q[22:0], sq_ge};
    dv_rem2    = {rem_q, dq_q[63]};
    dv_ge      = (dv_rem2 >= {3'b000, dvs_q});
    dv_rem_nx  = dv_ge ? 26'(dv_rem2 - {3'b000, dvs_q}) : dv_rem2[25:0];
  end

  // ---------------------------------------------------------------------------
  // Checks and small arithmetic
  // ---------------------------------------------------------------------------
  logic signed [31:0] kx_w, ky_w, kz_w;
  logic               hs_drop, chk_ok;
  logic        [17:0] k2_c;
  logic signed [8:0]  klos_c;
  logic        [23:0] start24, width24, diff24;
  logic               kmag_lt, ik_bad, bin_bad, last_step, cnt_sat;
  logic        [6:0]  imu_c;
  logic        [14:0] bin_c;
  logic        [39:0] mu_dvd;
  logic        [13:0] n_prod;
  logic        [6:0]  n_c;
  logic               kx_pos, ky_pos;

  always_comb begin
    kx_w    = 32'(signed'(kx_q));
    ky_w    = 32'(signed'(ky_q));
    kz_w    = 32'({1'b0, kz_q});
    kx_pos  = (kx_w > 0);
    ky_pos  = (ky_w > 0);
    hs_drop = (kz_w >= psb_pkg::HALF) || (kx_w > psb_pkg::HALF) ||
              (kx_w < psb_pkg::LOW_WAVE) || (ky_w > psb_pkg::HALF) ||
              (ky_w < psb_pkg::LOW_WAVE) ||
              ((kz_q == 8'd0) && !(kx_pos || ((kx_q == 8'd0) && ky_pos)));
    k2_c    = 18'(kx_w * kx_w) + 18'(ky_w * ky_w) + 18'(kz_w * kz_w);
    case (sight_q)
      psb_pkg::AXIS_X: klos_c = 9'(kx_w);
      psb_pkg::AXIS_Y: klos_c = 9'(ky_w);
      default:         klos_c = 9'(kz_w);
    endcase
    chk_ok  = !hs_drop && (k2_c != 18'd0) && (mu_bins_q != 7'd0) && !klos_c[8];

    start24 = {k_start_q, 8'h00};
    width24 = {(k_width_q == 16'd0) ? 16'd1 : k_width_q, 8'h00};
    kmag_lt = (root_q < start24);
    diff24  = root_q - start24;
    ik_bad  = (dq_q[23:0] >= {17'd0, k_bins_q});

    imu_c   = (root_q[13:0] >= {7'd0, mu_bins_q}) ? 7'(mu_bins_q - 7'd1) : root_q[6:0];
    bin_c   = {1'b0, prod_q[13:0]} + {8'd0, imu_c};
    bin_bad = (32'(bin_c) >= psb_pkg::MAX_BINS);
    mu_dvd  = {1'b0, klos_q, 32'd0} + {17'd0, kmag_q[23:1]};

    n_prod  = 14'(k_bins_q * mu_bins_q);
    n_c     = (32'(n_prod) > psb_pkg::MAX_BINS) ? 7'(psb_pkg::MAX_BINS) : n_prod[6:0];

    last_step = (cnt_q == 7'd1);
    ent_addr  = (state_q == psb_pkg::S_UPD) ? bin_q : idx_q;
    ent       = bv_q[ent_addr] ? psb_pkg::bin_entry_t'(ram_rdata) : '0;
    cnt_sat   = (ent.count == psb_pkg::CNT_MAX);
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      psb_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i == psb_pkg::CMD_FINISH) begin
            state_d = (n_c == 7'd0) ? psb_pkg::S_IDLE : psb_pkg::S_FRD;
          end else begin
            state_d = psb_pkg::S_CHK;
          end
        end
      end
      psb_pkg::S_CHK:   state_d = chk_ok ? psb_pkg::S_SQK : psb_pkg::S_IDLE;
      psb_pkg::S_SQK:   if (last_step) state_d = psb_pkg::S_KCHK;
      psb_pkg::S_KCHK:  state_d = kmag_lt ? psb_pkg::S_IDLE : psb_pkg::S_KDIV;
      psb_pkg::S_KDIV:  if (last_step) state_d = psb_pkg::S_KQ;
      psb_pkg::S_KQ:    state_d = ik_bad ? psb_pkg::S_IDLE : psb_pkg::S_MT;
      psb_pkg::S_MT:    state_d = psb_pkg::S_MTT;
      psb_pkg::S_MTT:   state_d = psb_pkg::S_QDIV;
      psb_pkg::S_QDIV:  if (last_step) state_d = psb_pkg::S_QQ;
      psb_pkg::S_QQ:    state_d = psb_pkg::S_QSQ;
      psb_pkg::S_QSQ:   if (last_step) state_d = psb_pkg::S_MUB;
      psb_pkg::S_MUB:   state_d = bin_bad ? psb_pkg::S_IDLE : psb_pkg::S_MUDIV;
      psb_pkg::S_MUDIV: if (last_step) state_d = psb_pkg::S_XP1;
      psb_pkg::S_XP1:   state_d = psb_pkg::S_XP2;
      psb_pkg::S_XP2:   state_d = psb_pkg::S_XF;
      psb_pkg::S_XF:    state_d = psb_pkg::S_XW1;
      psb_pkg::S_XW1:   state_d = psb_pkg::S_XW2;
      psb_pkg::S_XW2:   state_d = psb_pkg::S_XW3;
      psb_pkg::S_XW3:   state_d = psb_pkg::S_UPD;
      psb_pkg::S_UPD:   state_d = psb_pkg::S_IDLE;
      psb_pkg::S_FRD:   state_d = psb_pkg::S_FWT;
      psb_pkg::S_FWT:   state_d = (ent.count == 24'd0) ? psb_pkg::S_FNX : psb_pkg::S_FDK;
      psb_pkg::S_FDK:   if (last_step) state_d = psb_pkg::S_FMK;
      psb_pkg::S_FMK:   state_d = psb_pkg::S_FDM;
      psb_pkg::S_FDM:   if (last_step) state_d = psb_pkg::S_FMM;
      psb_pkg::S_FMM:   state_d = psb_pkg::S_FDP;
      psb_pkg::S_FDP:   if (last_step) state_d = psb_pkg::S_FS1;
      psb_pkg::S_FS1:   state_d = psb_pkg::S_FS2;
      psb_pkg::S_FS2:   state_d = psb_pkg::S_FS3;
      psb_pkg::S_FS3:   state_d = psb_pkg::S_FNX;
      psb_pkg::S_FNX:   state_d = last_q ? psb_pkg::S_IDLE : psb_pkg::S_FRD;
      default:          state_d = psb_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs: multiplier operands and store access
  // ---------------------------------------------------------------------------
  logic [63:0] m_mag;
  assign m_mag = dq_q;

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    case (state_q)
      psb_pkg::S_KQ: begin
        mul_a = 33'({klos_q});
        mul_b = 33'({mu_bins_q});
      end
      psb_pkg::S_MT: begin
        mul_a = 33'({prod_q[13:0]});
        mul_b = 33'({prod_q[13:0]});
      end
      psb_pkg::S_QSQ: begin
        mul_a = 33'({ik_q});
        mul_b = 33'({mu_bins_q});
      end
      psb_pkg::S_MUB: begin
        ram_re    = !bin_bad;
        ram_raddr = bin_c[AW-1:0];
      end
      psb_pkg::S_XP1: begin
        mul_a = (part_q == psb_pkg::PART_REAL) ? 33'(are_q) : 33'(aim_q);
        mul_b = 33'(bre_q);
      end
      psb_pkg::S_XP2: begin
        mul_a = (part_q == psb_pkg::PART_REAL) ? 33'(aim_q) : 33'(are_q);
        mul_b = 33'(bim_q);
      end
      psb_pkg::S_XW1: begin
        mul_a = 33'({1'b0, fm_q[47:16]});
        mul_b = 33'({1'b0, w_q});
      end
      psb_pkg::S_XW2: begin
        mul_a = 33'({1'b0, fm_q[15:0]});
        mul_b = 33'({1'b0, w_q});
      end
      psb_pkg::S_FRD: begin
        ram_re = 1'b1;
      end
      psb_pkg::S_FS1: begin
        mul_a = 33'({1'b0, m_mag[63:32]});
        mul_b = 33'({1'b0, scale_q});
      end
      psb_pkg::S_FS2: begin
        mul_a = 33'({1'b0, m_mag[31:0]});
        mul_b = 33'({1'b0, scale_q});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bin update: saturating sums, dropped when the count is full
  // ---------------------------------------------------------------------------
  logic [40:0] ksum_c, musum_c;
  logic signed [64:0] psum_c;

  always_comb begin
    ksum_c  = {1'b0, ent.k_sum} + {17'd0, kmag_q};
    musum_c = {1'b0, ent.mu_sum} + {24'd0, mu_q};
    psum_c  = {ent.power_sum[63], ent.power_sum} + {term_q[63], term_q};
    ram_wdata.count  = ent.count + 24'd1;
    ram_wdata.k_sum  = ksum_c[40] ? {40{1'b1}} : ksum_c[39:0];
    ram_wdata.mu_sum = musum_c[40] ? {40{1'b1}} : musum_c[39:0];
    if (psum_c[64] != psum_c[63]) begin
      ram_wdata.power_sum = psum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      ram_wdata.power_sum = psum_c[63:0];
    end
    ram_we = (state_q == psb_pkg::S_UPD) && !cnt_sat;
  end

  psb_ram #(
    .WIDTH (psb_pkg::ENTRY_W),
    .DEPTH (psb_pkg::MAX_BINS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Cross power and output scaling helpers
  // ---------------------------------------------------------------------------
  logic        [65:0] prod_mag;
  logic signed [48:0] trunc_c;
  logic signed [49:0] f_c;
  logic        [49:0] f_mag;
  logic        [52:0] tm_c;
  logic        [48:0] r_c, r_sum;
  logic signed [50:0] p_c;
  logic signed [47:0] p_sat;
  logic        [63:0] psum_mag;

  always_comb begin
    // product cut to Q.16 toward zero
    prod_mag = prod_q[65] ? 66'(-prod_q) : prod_q;
    trunc_c  = prod_q[65] ? -signed'({1'b0, prod_mag[63:16]}) : signed'({1'b0, prod_mag[63:16]});
    f_c      = (part_q == psb_pkg::PART_REAL) ? (50'(t1_q) + 50'(trunc_c))
                                              : (50'(t1_q) - 50'(trunc_c));
    f_mag    = f_c[49] ? 50'(-f_c) : f_c;
    tm_c     = hi_q[52:0] + {17'd0, prod_q[51:16]};

    // mean * scale, limited to 2^48, signed, minus shot noise
    r_sum = {2'b00, hi_q[30:0], 16'd0} + {1'b0, prod_q[63:16]};
    if (hi_q >= 64'h8000_0000) begin
      r_c = {1'b1, 48'd0};
    end else if (r_sum > {1'b1, 48'd0}) begin
      r_c = {1'b1, 48'd0};
    end else begin
      r_c = r_sum;
    end
    p_c = (psum_q[63] ? -signed'({2'b00, r_c}) : signed'({2'b00, r_c})) - 51'(shot_q);
    if (p_c > 51'sh7FFF_FFFF_FFFF) begin
      p_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (p_c < -51'sh8000_0000_0000) begin
      p_sat = -48'sh8000_0000_0000;
    end else begin
      p_sat = p_c[47:0];
    end
    psum_mag = ent.power_sum[63] ? 64'(-ent.power_sum) : ent.power_sum;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psb_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      bv_q        <= '0;
      k_start_q   <= 16'd0;
      k_width_q   <= 16'd256;
      k_bins_q    <= 7'd8;
      mu_bins_q   <= 7'd8;
      sight_q     <= 2'd2;
      part_q      <= 1'b0;
      shot_q      <= '0;
      scale_q     <= 32'd65536;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_d == psb_pkg::S_FNX);
      if (ram_we) begin
        bv_q[bin_q] <= 1'b1;
      end
      // drop the whole store once the last bin is out, or at a finish with no bins
      if ((state_q == psb_pkg::S_FNX && last_q) ||
          (accept && cmd_i == psb_pkg::CMD_FINISH && n_c == 7'd0)) begin
        bv_q <= '0;
      end
      if (cfg_we_i) begin
        case (psb_pkg::cfg_idx_e'(cfg_idx_i))
          psb_pkg::CFG_K_START:     k_start_q <= cfg_data_i[15:0];
          psb_pkg::CFG_K_WIDTH:     k_width_q <= cfg_data_i[15:0];
          psb_pkg::CFG_K_BINS:      k_bins_q  <= cfg_data_i[6:0];
          psb_pkg::CFG_MU_BINS:     mu_bins_q <= cfg_data_i[6:0];
          psb_pkg::CFG_SIGHT_AXIS:  sight_q   <= cfg_data_i[1:0];
          psb_pkg::CFG_PART_SELECT: part_q    <= cfg_data_i[0];
          psb_pkg::CFG_SHOT_NOISE:  shot_q    <= cfg_data_i;
          psb_pkg::CFG_POWER_SCALE: scale_q   <= cfg_data_i[31:0];
          default:                  part_q    <= part_q;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      psb_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q <= cmd_i;
          kx_q  <= wave_x_i;
          ky_q  <= wave_y_i;
          kz_q  <= wave_z_i;
          are_q <= a_re_i;
          aim_q <= a_im_i;
          bre_q <= b_re_i;
          bim_q <= b_im_i;
          w_q   <= weight_i;
          n_q   <= n_c;
          idx_q <= '0;
        end
      end
      psb_pkg::S_CHK: begin
        k2_q   <= k2_c[15:0];
        klos_q <= klos_c[6:0];
        rem_q  <= '0;
        root_q <= '0;
        dq_q   <= {k2_c[15:0], 48'd0};
        cnt_q  <= 7'd24;
      end
      psb_pkg::S_SQK, psb_pkg::S_QSQ: begin
        rem_q  <= sq_rem_nx;
        root_q <= sq_root_nx;
        dq_q   <= {dq_q[61:0], 2'b00};
        cnt_q  <= cnt_q - 7'd1;
      end
      psb_pkg::S_KDIV, psb_pkg::S_QDIV, psb_pkg::S_MUDIV,
      psb_pkg::S_FDK, psb_pkg::S_FDM, psb_pkg::S_FDP: begin
        rem_q <= dv_rem_nx;
        dq_q  <= {dq_q[62:0], dv_ge};
        cnt_q <= cnt_q - 7'd1;
      end
      psb_pkg::S_KCHK: begin
        kmag_q <= root_q;
        rem_q  <= '0;
        dq_q   <= {diff24, 40'd0};
        dvs_q  <= width24;
        cnt_q  <= 7'd24;
      end
      psb_pkg::S_KQ: begin
        ik_q <= dq_q[6:0];
      end
      psb_pkg::S_MTT: begin
        rem_q <= '0;
        dq_q  <= {prod_q[27:0], 36'd0};
        dvs_q <= {8'd0, k2_q};
        cnt_q <= 7'd28;
      end
      psb_pkg::S_QQ: begin
        rem_q  <= '0;
        root_q <= '0;
        dq_q   <= {dq_q[27:0], 36'd0};
        cnt_q  <= 7'd14;
      end
      psb_pkg::S_MUB: begin
        bin_q <= bin_c[AW-1:0];
        rem_q <= {4'd0, mu_dvd[39:18]};
        dq_q  <= {mu_dvd[17:0], 46'd0};
        dvs_q <= kmag_q;
        cnt_q <= 7'd18;
      end
      psb_pkg::S_XP1: begin
        mu_q <= (dq_q[17:0] > 18'd65536) ? 17'h10000 : dq_q[16:0];
      end
      psb_pkg::S_XP2: begin
        t1_q <= trunc_c;
      end
      psb_pkg::S_XF: begin
        fm_q   <= f_mag[47:0];
        fneg_q <= f_c[49];
      end
      psb_pkg::S_XW2, psb_pkg::S_FS2: begin
        hi_q <= prod_q[63:0];
      end
      psb_pkg::S_XW3: begin
        term_q <= fneg_q ? -signed'({11'd0, tm_c}) : signed'({11'd0, tm_c});
      end
      psb_pkg::S_FWT: begin
        bin_index_q  <= 6'(idx_q);
        mode_count_q <= ent.count;
        last_q       <= ({1'b0, 6'(idx_q)} + 7'd1 == n_q);
        mean_k_q     <= '0;
        mean_mu_q    <= '0;
        power_q      <= '0;
        psum_q       <= ent.power_sum;
        dvs_q        <= ent.count;
        rem_q        <= '0;
        dq_q         <= {ent.k_sum, 24'd0};
        cnt_q        <= 7'd40;
        // hold the magnitude of the power sum for the third division
        hi_q         <= psum_mag;
        fm_q         <= ent.mu_sum[39:0] >> 0 == 40'd0 ? 48'd0 : {8'd0, ent.mu_sum};
      end
      psb_pkg::S_FMK: begin
        mean_k_q <= (dq_q[39:24] != 16'd0) ? psb_pkg::CNT_MAX : dq_q[23:0];
        rem_q    <= '0;
        dq_q     <= {fm_q[39:0], 24'd0};
        cnt_q    <= 7'd40;
      end
      psb_pkg::S_FMM: begin
        mean_mu_q <= signed'(dq_q[17:0]);
        rem_q     <= '0;
        dq_q      <= hi_q;
        cnt_q     <= 7'd64;
      end
      psb_pkg::S_FS3: begin
        power_q <= p_sat;
      end
      psb_pkg::S_FNX: begin
        idx_q <= AW'(idx_q + 1'b1);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign valid_o      = out_valid_q;
  assign bin_index_o  = bin_index_q;
  assign mode_count_o = mode_count_q;
  assign mean_k_o     = mean_k_q;
  assign mean_mu_o    = mean_mu_q;
  assign power_o      = power_q;
  assign last_o       = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe outside a finish run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> (!busy && bv_q == '0))
    else $error("finish run did not end and clear the store after last");

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("block went busy without a request");

  a_store_write_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cmd_q == psb_pkg::CMD_ACCUM))
    else $error("store written during a finish run");

endmodule

/* tb/tb_power_spectrum_2d_binner.sv */
// Self-checking testbench of the (k, mu) power spectrum binner.
`timescale 1ns / 100ps

module tb_power_spectrum_2d_binner;
  import psb_pkg::*;

  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          DRAIN_WAIT  = 300;
  localparam longint      P48_HI      = 64'sd140737488355327;
  localparam longint      P48_LO      = -64'sd140737488355328;
  localparam longint unsigned SUM40_TOP = 64'hFF_FFFF_FFFF;

  // One request row: typed_empty marks a finish whose results are typed in
  // directly (every bin empty), not taken from the predictor.
  typedef struct {
    logic               cmd;
    logic        [7:0]  wx;
    logic        [7:0]  wy;
    logic        [7:0]  wz;
    logic signed [31:0] are;
    logic signed [31:0] aim;
    logic signed [31:0] bre;
    logic signed [31:0] bim;
    logic        [19:0] wt;
    bit                 typed_empty;
  } mode_req_t;

  typedef struct {
    logic        [5:0]  idx;
    logic        [23:0] cnt;
    logic        [23:0] mk;
    logic        [17:0] mmu;
    logic        [47:0] pwr;
    logic               lst;
  } bin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = CMD_ACCUM;
  logic        [7:0]  wave_x_i = '0, wave_y_i = '0, wave_z_i = '0;
  logic signed [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic        [19:0] weight_i = '0;
  logic               cfg_we_i = 1'b0;
  logic        [2:0]  cfg_idx_i = '0;
  logic        [47:0] cfg_data_i = '0;
  logic               valid_o;
  logic        [5:0]  bin_index_o;
  logic        [23:0] mode_count_o;
  logic        [23:0] mean_k_o;
  logic signed [17:0] mean_mu_o;
  logic signed [47:0] power_o;
  logic               last_o;

  power_spectrum_2d_binner u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i,
    .wave_x_i, .wave_y_i, .wave_z_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i, .weight_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .valid_o, .bin_index_o, .mode_count_o, .mean_k_o, .mean_mu_o, .power_o, .last_o
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of the registers and the bin store.
  logic [15:0] k_start_r, k_width_r;
  logic [6:0]  k_bins_r, mu_bins_r;
  logic [1:0]  sight_r;
  logic        part_r;
  logic signed [47:0] shot_r;
  logic [31:0] scale_r;
  longint unsigned   store_cnt [MAX_BINS];
  longint unsigned   store_k   [MAX_BINS];
  longint unsigned   store_mu  [MAX_BINS];
  longint            store_pwr [MAX_BINS];

  bin_result_t bin_results_q[$];
  int          errs = 0;
  int          cycles = 0;
  int          idle_pct = 11;
  int          sent = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cut16(longint x);
    longint unsigned m;
    m = x < 0 ? -x : x;
    return x < 0 ? -longint'(m >> 16) : longint'(m >> 16);
  endfunction

  function automatic void clear_store();
    foreach (store_cnt[i]) begin
      store_cnt[i] = 0; store_k[i] = 0; store_mu[i] = 0; store_pwr[i] = 0;
    end
  endfunction

  // Bin one mode into the predictor store, or drop it.
  function automatic void bin_mode(mode_req_t q);
    longint kx, ky, kz, klos, f, term, s;
    longint unsigned k2, kmag, kstart, kwid, ik, t, imu, bin, mu, fm, tm, w;
    kx = longint'(signed'(q.wx));
    ky = longint'(signed'(q.wy));
    kz = longint'(q.wz);
    if (kz >= HALF || kx > HALF || kx < LOW_WAVE || ky > HALF || ky < LOW_WAVE) return;
    if (kz == 0 && !(kx > 0 || (kx == 0 && ky > 0))) return;
    k2 = kx * kx + ky * ky + kz * kz;
    if (k2 == 0 || mu_bins_r == 0) return;
    klos = sight_r == AXIS_X ? kx : (sight_r == AXIS_Y ? ky : kz);
    if (klos < 0) return;  // drop negative line of sight
    kmag = int_sqrt(k2 << 32);
    kstart = longint'(k_start_r) << 8;
    kwid = longint'(k_width_r != 0 ? k_width_r : 16'd1) << 8;
    if (kmag < kstart) return;
    ik = (kmag - kstart) / kwid;
    if (ik >= k_bins_r) return;
    t = klos * mu_bins_r;
    imu = int_sqrt((t * t) / k2);
    if (imu >= mu_bins_r) imu = mu_bins_r - 1;
    bin = ik * mu_bins_r + imu;
    if (bin >= MAX_BINS) return;
    if (store_cnt[bin] >= CNT_MAX) return;
    mu = ((longint'(klos) << 32) + kmag / 2) / kmag;
    if (mu > 65536) mu = 65536;
    if (part_r == PART_REAL)
      f = cut16(longint'(q.are) * longint'(q.bre)) + cut16(longint'(q.aim) * longint'(q.bim));
    else
      f = cut16(longint'(q.aim) * longint'(q.bre)) - cut16(longint'(q.are) * longint'(q.bim));
    w = q.wt;
    fm = f < 0 ? -f : f;
    tm = (fm >> 16) * w + (((fm & 64'hFFFF) * w) >> 16);
    term = f < 0 ? -longint'(tm) : longint'(tm);
    store_cnt[bin]++;
    store_k[bin] = store_k[bin] + kmag > SUM40_TOP ? SUM40_TOP : store_k[bin] + kmag;
    store_mu[bin] = store_mu[bin] + mu > SUM40_TOP ? SUM40_TOP : store_mu[bin] + mu;
    s = store_pwr[bin];
    if (term > 0 && s > 64'sh7FFF_FFFF_FFFF_FFFF - term) s = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (term < 0 && s < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - term)
      s = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    else s += term;
    store_pwr[bin] = s;
  endfunction

  function automatic longint scaled_power(longint sum, longint unsigned c);
    longint mean, p;
    longint unsigned m, sc, hi, r;
    mean = sum / longint'(c);
    m = mean < 0 ? -mean : mean;
    sc = scale_r;
    hi = (m >> 32) * sc;
    if (hi >= (64'h1 << 31)) r = 64'h1 << 48;
    else begin
      r = (hi << 16) + (((m & 64'hFFFF_FFFF) * sc) >> 16);
      if (r > (64'h1 << 48)) r = 64'h1 << 48;
    end
    p = mean < 0 ? -longint'(r) : longint'(r);
    p -= longint'(shot_r);
    if (p > P48_HI) p = P48_HI;
    if (p < P48_LO) p = P48_LO;
    return p;
  endfunction

  // Queue the results of a finish, then clear the store.
  function automatic void emit_bins();
    int n;
    bin_result_t e;
    longint unsigned mk;
    n = int'(k_bins_r) * int'(mu_bins_r);
    if (n > MAX_BINS) n = MAX_BINS;
    for (int i = 0; i < n; i++) begin
      e = '{idx: i[5:0], cnt: store_cnt[i][23:0], mk: '0, mmu: '0, pwr: '0,
            lst: (i + 1 == n)};
      if (store_cnt[i] > 0) begin
        mk = store_k[i] / store_cnt[i];
        e.mk = mk > CNT_MAX ? CNT_MAX : mk[23:0];
        e.mmu = 18'((store_mu[i] / store_cnt[i]) & 64'h3FFFF);
        e.pwr = 48'(scaled_power(store_pwr[i], store_cnt[i]));
      end
      bin_results_q.push_back(e);
    end
    clear_store();
  endfunction

  // Drive one request, hold it until taken, then predict it.
  task automatic send_request(mode_req_t q);
    bin_result_t e;
    start <= 1'b1;
    cmd_i <= q.cmd;
    wave_x_i <= q.wx; wave_y_i <= q.wy; wave_z_i <= q.wz;
    a_re_i <= q.are; a_im_i <= q.aim; b_re_i <= q.bre; b_im_i <= q.bim;
    weight_i <= q.wt;
    do @(posedge clk_i); while (busy);
    sent++;
    if (q.cmd == CMD_FINISH && q.typed_empty) begin
      for (int i = 0; i < MAX_BINS; i++) begin
        e = '{idx: i[5:0], cnt: '0, mk: '0, mmu: '0, pwr: '0, lst: (i == MAX_BINS - 1)};
        bin_results_q.push_back(e);
      end
      clear_store();
    end else if (q.cmd == CMD_FINISH) begin
      emit_bins();
    end else begin
      bin_mode(q);
    end
    idle_pct = sent < 153 ? 11 : (sent < 306 ? 79 : 0);
    // Drop start for a random gap, or keep it high for the next request.
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Wait until the block is idle and every result is in.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || bin_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [47:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      case (cfg_idx_e'(i))
        CFG_K_START:     k_start_r = v[i][15:0];
        CFG_K_WIDTH:     k_width_r = v[i][15:0];
        CFG_K_BINS:      k_bins_r = v[i][6:0];
        CFG_MU_BINS:     mu_bins_r = v[i][6:0];
        CFG_SIGHT_AXIS:  sight_r = v[i][1:0];
        CFG_PART_SELECT: part_r = v[i][0];
        CFG_SHOT_NOISE:  shot_r = v[i][47:0];
        CFG_POWER_SCALE: scale_r = v[i][31:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic mode_req_t random_mode(bit finish_ok);
    mode_req_t q;
    int r;
    q.typed_empty = 0;
    q.cmd = (finish_ok && $urandom_range(99) < 5) ? CMD_FINISH : CMD_ACCUM;
    r = $urandom_range(2) == 0 ? 127 : ($urandom_range(1) ? 40 : 10);
    if ($urandom_range(99) < 15) begin
      // noise: any bit pattern, mostly dropped
      q.wx = 8'($urandom); q.wy = 8'($urandom); q.wz = 8'($urandom);
    end else begin
      q.wx = 8'($urandom_range(2 * r) - r);
      q.wy = 8'($urandom_range(2 * r) - r);
      q.wz = 8'($urandom_range(r));
    end
    if ($urandom_range(1)) begin
      q.are = $urandom; q.aim = $urandom; q.bre = $urandom; q.bim = $urandom;
    end else begin
      q.are = $urandom_range(1 << 21) - (1 << 20);
      q.aim = $urandom_range(1 << 21) - (1 << 20);
      q.bre = $urandom_range(1 << 21) - (1 << 20);
      q.bim = $urandom_range(1 << 21) - (1 << 20);
    end
    q.wt = 20'($urandom);
    return q;
  endfunction

  // Results cannot be held off: check each one at the edge that ends its cycle.
  always @(posedge clk_i) begin
    bin_result_t e;
    if (rst_ni && valid_o) begin
      if (bin_results_q.size() == 0) begin
        $display("%0t: unexpected result bin %0d", $time, bin_index_o);
        errs++;
      end else begin
        e = bin_results_q.pop_front();
        if (bin_index_o !== e.idx) begin
          $display("%0t: bin_index expected %0d actual %0d", $time, e.idx, bin_index_o);
          errs++;
        end
        if (mode_count_o !== e.cnt) begin
          $display("%0t: mode_count expected %0d actual %0d", $time, e.cnt, mode_count_o);
          errs++;
        end
        if (mean_k_o !== e.mk) begin
          $display("%0t: mean_k expected %0d actual %0d", $time, e.mk, mean_k_o);
          errs++;
        end
        if (mean_mu_o !== e.mmu) begin
          $display("%0t: mean_mu expected %0d actual %0d", $time,
                   $signed(e.mmu), mean_mu_o);
          errs++;
        end
        if (power_o !== e.pwr) begin
          $display("%0t: power expected %0d actual %0d", $time, $signed(e.pwr), power_o);
          errs++;
        end
        if (last_o !== e.lst) begin
          $display("%0t: last expected %0b actual %0b", $time, e.lst, last_o);
          errs++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Directed rows under the reset settings (k bins of one grid unit, z sight).
  localparam logic signed [31:0] AMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] AMIN = -32'sh7FFF_FFFF - 1;
  mode_req_t directed [] = '{
    '{CMD_FINISH, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 20'd0, 1},      // empty store after reset
    '{CMD_ACCUM, 8'd1, 8'd0, 8'd0, AMAX, AMAX, AMAX, AMAX, 20'hFFFFF, 0},
    '{CMD_ACCUM, 8'd0, 8'd1, 8'd0, AMIN, AMAX, AMAX, AMIN, 20'hFFFFF, 0},
    '{CMD_ACCUM, 8'd0, 8'd0, 8'd0, AMAX, AMAX, AMAX, AMAX, 20'h10000, 0},   // origin
    '{CMD_ACCUM, 8'd0, -8'sd5, 8'd0, 1 << 16, 0, 1 << 16, 0, 20'h10000, 0},
    '{CMD_ACCUM, -8'sd3, 8'd4, 8'd0, 1 << 16, 0, 1 << 16, 0, 20'h10000, 0},
    '{CMD_ACCUM, 8'd127, 8'd127, 8'd127, 5, 6, 7, 8, 20'h10000, 0},
    '{CMD_ACCUM, -8'sd128, 8'd5, 8'd3, 5, 6, 7, 8, 20'h10000, 0},      // past the edge
    '{CMD_ACCUM, -8'sd127, -8'sd127, 8'd1, 5, 6, 7, 8, 20'h10000, 0},
    '{CMD_ACCUM, 8'd2, -8'sd3, 8'd5, AMIN, AMIN, AMIN, AMIN, 20'hFFFFF, 0},
    '{CMD_ACCUM, 8'd0, 8'd0, 8'd7, AMAX, AMIN, AMIN, AMAX, 20'h8000, 0},  // mu of one
    '{CMD_ACCUM, 8'd1, 8'd1, 8'd1, AMAX, AMAX, AMAX, AMAX, 20'd0, 0},
    '{CMD_ACCUM, 8'd3, 8'd0, 8'd4, -32'sd100000, 32'sd7, 32'sd900000, 32'sd3,
      20'h1_8000, 0},
    '{CMD_ACCUM, 8'd0, 8'd1, 8'd128, 5, 6, 7, 8, 20'h10000, 0},       // z past the half
    '{CMD_ACCUM, 8'd0, 8'd1, 8'd255, 5, 6, 7, 8, 20'h10000, 0},
    '{CMD_FINISH, 8'hFF, 8'hFF, 8'hFF, AMAX, AMAX, AMAX, AMAX, 20'hFFFFF, 0}
  };

  // Register sets per phase: k_start, k_width, k_bins, mu_bins, sight, part,
  // shot noise, power scale.
  logic [47:0] phase_regs [7][8] = '{
    '{48'h0,    48'h0400, 48'd16,  48'd4,   48'd0, 48'd1, 48'h8000_0000_0000, 48'hFFFF_FFFF},
    '{48'h0280, 48'h0,    48'd64,  48'd1,   48'd1, 48'd0, 48'h7FFF_FFFF_FFFF, 48'h0},
    '{48'hFFFF, 48'hFFFF, 48'd1,   48'd64,  48'd3, 48'd1, 48'h8000_0000_0000, 48'h1},
    '{48'h0,    48'hFFFF, 48'd127, 48'd127, 48'd2, 48'd0, 48'h0,              48'h1_0000},
    '{48'h0,    48'h0100, 48'd0,   48'd8,   48'd2, 48'd0, 48'h0,              48'h1_0000},
    '{48'h0,    48'h0100, 48'd8,   48'd0,   48'd0, 48'd1, 48'h3039,           48'h1_0000},
    '{48'h0100, 48'h1000, 48'd8,   48'd8,   48'd2, 48'd0, 48'h3039,           48'h3_0000}
  };
  int phase_items [7] = '{60, 60, 45, 60, 30, 30, 160};

  initial begin
    mode_req_t fin;
    k_start_r = 0; k_width_r = 256; k_bins_r = 8; mu_bins_r = 8;
    sight_r = 2; part_r = PART_REAL; shot_r = 0; scale_r = 32'h1_0000;
    clear_store();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    fin = directed[$size(directed) - 1];
    foreach (phase_regs[p]) begin
      write_regs(phase_regs[p]);
      for (int i = 0; i < phase_items[p]; i++) send_request(random_mode(1));
      send_request(fin);
      drain();
    end

    if (errs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
